>>> rtl/dps_pkg.sv
`timescale 1ns / 1ps

package dps_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic signed [7:0] PRI_MIN = 8'sh80;
   localparam logic [15:0]       RUN_MAX = 16'hFFFF;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         id;
      logic signed [7:0]  pri;
      logic [15:0]        need;
   } cmd_type;

   typedef struct packed {
      logic [7:0]         id;
      logic signed [7:0]  pri;
      logic [15:0]        need;
      logic [15:0]        run;
      logic [31:0]        stamp;
   } entry_type;

   typedef struct packed {
      logic        add_accepted;
      logic        ran_valid;
      logic [7:0]  ran_id;
      logic signed [7:0] ran_priority;
      logic [15:0] ran_time;
      logic        finished;
      logic        queue_empty;
   } rsp_type;

endpackage

>>> rtl/dps_front.sv
`timescale 1ns / 1ps

module dps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [7:0]          req_process_id,
   input  logic signed [7:0]   req_priority_req,
   input  logic [15:0]         req_need_time,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output dps_pkg::cmd_type    cmd
);
   import dps_pkg::*;

   cmd_type             slots_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   cmd_type             new_cmd;
   logic                push, pop;

   // classify the incoming word
   always_comb begin
      new_cmd.op   = req_operation ? OP_TICK : OP_ADD;
      new_cmd.id   = req_process_id;
      new_cmd.pri  = req_priority_req;
      new_cmd.need = req_need_time;
   end

   assign req_ready = (fill_ff != QCNT_W'(QDEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = slots_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = QCNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = QCNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> rtl/dps_engine.sv
`timescale 1ns / 1ps

module dps_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  dps_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dps_pkg::rsp_type  rsp
);
   import dps_pkg::*;

   entry_type           entry_mem [ENTRIES];
   entry_type           rd_data_ff;

   state_type           state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [CNT_W-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]    pipe_idx_ff, pipe_idx_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                best_found_ff, best_found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   entry_type           best_ff, best_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [31:0]         counter_ff, counter_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                scan_end, out_free, commit, rd_en, live, better;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;
   logic signed [7:0]   new_pri;
   logic [15:0]         new_run;
   logic                done;

   assign scan_end  = (scan_cnt_ff == CNT_W'(ENTRIES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_ready = 1'b0;
      rd_en     = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   cmd_ready = 1'b1;
         ST_SCAN:   rd_en     = !scan_end;
         ST_FINISH: commit    = out_free;
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      new_pri = (best_ff.pri == PRI_MIN) ? best_ff.pri : 8'(best_ff.pri - 8'sd1);
      new_run = (best_ff.run == RUN_MAX) ? best_ff.run : 16'(best_ff.run + 16'd1);
      done    = (new_run >= best_ff.need);
      live    = valid_ff[pipe_idx_ff];
      better  = !best_found_ff || (rd_data_ff.pri > best_ff.pri) ||
                ((rd_data_ff.pri == best_ff.pri) && (rd_data_ff.stamp > best_ff.stamp));
   end

   // datapath updates
   always_comb begin
      cur_in        = cur_ff;
      scan_cnt_in   = scan_cnt_ff;
      pipe_vld_in   = rd_en;
      pipe_idx_in   = scan_cnt_ff[IDX_W-1:0];
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      counter_in    = counter_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = best_idx_ff;
      wr_data       = best_ff;

      if (cmd_ready && cmd_valid) begin
         cur_in        = cmd;
         scan_cnt_in   = '0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end

      if (rd_en) begin
         scan_cnt_in = CNT_W'(scan_cnt_ff + 1'b1);
      end

      if (pipe_vld_ff) begin
         if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pipe_idx_ff;
         end
         if (live && better) begin
            best_found_in = 1'b1;
            best_idx_in   = pipe_idx_ff;
            best_in       = rd_data_ff;
         end
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (cur_ff.op == OP_ADD) begin
            rsp_in.queue_empty = (count_ff == '0);
            if (free_found_ff) begin
               wr_en         = 1'b1;
               wr_addr       = free_idx_ff;
               wr_data.id    = cur_ff.id;
               wr_data.pri   = cur_ff.pri;
               wr_data.need  = cur_ff.need;
               wr_data.run   = '0;
               wr_data.stamp = counter_ff;
               valid_in[free_idx_ff] = 1'b1;
               count_in      = CNT_W'(count_ff + 1'b1);
               counter_in    = counter_ff + 32'd1;
               rsp_in.add_accepted = 1'b1;
               rsp_in.queue_empty  = 1'b0;
            end
         end else begin
            rsp_in.queue_empty = 1'b1;
            if (best_found_ff) begin
               rsp_in.ran_valid    = 1'b1;
               rsp_in.ran_id       = best_ff.id;
               rsp_in.ran_priority = new_pri;
               rsp_in.ran_time     = new_run;
               rsp_in.finished     = done;
               if (done) begin
                  valid_in[best_idx_ff] = 1'b0;
                  count_in           = CNT_W'(count_ff - 1'b1);
                  rsp_in.queue_empty = (count_ff == CNT_W'(1));
               end else begin
                  wr_en              = 1'b1;
                  wr_data.pri        = new_pri;
                  wr_data.run        = new_run;
                  wr_data.stamp      = counter_ff;
                  counter_in         = counter_ff + 32'd1;
                  rsp_in.queue_empty = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      scan_cnt_ff   <= scan_cnt_in;
      pipe_idx_ff   <= pipe_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[scan_cnt_ff[IDX_W-1:0]];
      end
   end

endmodule

>>> rtl/dynamic_priority_scheduler_core.sv
// Dynamic priority scheduler with aging. An add word inserts a process into the lowest free
// slot of a 16-entry ready table (add_accepted = 0 when full); a tick word dispatches the
// highest-priority process, newest first on ties, lowers its priority by one (floor -128),
// bumps its run time and retires it once run time reaches its need. Every word gives one
// result word. A two-word input queue decouples acceptance from execution; the engine
// walks the table one entry per cycle through a registered memory read port and takes
// a new word only once the scan and the result for the current word are done.
`timescale 1ns / 1ps

module dynamic_priority_scheduler_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [7:0]         req_process_id,
   input  logic signed [7:0]  req_priority_req,
   input  logic [15:0]        req_need_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_add_accepted,
   output logic               rsp_ran_valid,
   output logic [7:0]         rsp_ran_id,
   output logic signed [7:0]  rsp_ran_priority,
   output logic [15:0]        rsp_ran_time,
   output logic               rsp_finished,
   output logic               rsp_queue_empty
);
   import dps_pkg::*;

   logic     cmd_valid, cmd_ready;
   cmd_type  cmd;
   rsp_type  rsp;

   dps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_process_id   (req_process_id),
      .req_priority_req (req_priority_req),
      .req_need_time    (req_need_time),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   dps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_add_accepted = rsp.add_accepted;
   assign rsp_ran_valid    = rsp.ran_valid;
   assign rsp_ran_id       = rsp.ran_id;
   assign rsp_ran_priority = rsp.ran_priority;
   assign rsp_ran_time     = rsp.ran_time;
   assign rsp_finished     = rsp.finished;
   assign rsp_queue_empty  = rsp.queue_empty;

`ifndef SYNTHESIS
   a_add_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_add_accepted) |-> !rsp_queue_empty)
      else $error("accepted add reported an empty table");

   a_finish_needs_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_ran_valid && !rsp_add_accepted))
      else $error("retire without a dispatch");

   a_requeue_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ran_valid && !rsp_finished) |-> !rsp_queue_empty)
      else $error("reinserted process but table reported empty");
`endif

endmodule
